/* hw/rtl/bocc_pkg.sv */
package bocc_pkg;

  // Largest image the stores hold.
  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;

  // Width of the dimension registers and of the row and column indexes.
  localparam int unsigned DimW = 7;
  localparam int unsigned RowW = $clog2(MaxRows);
  localparam int unsigned ColW = $clog2(MaxCols);

  localparam logic [DimW-1:0] HeightReset = DimW'(MaxRows);
  localparam logic [DimW-1:0] WidthReset  = DimW'(MaxCols);

  typedef enum logic [0:0] {
    ActLoad = 1'b0,
    ActRead = 1'b1
  } action_e;

  typedef enum logic [0:0] {
    RegHeight = 1'b0,
    RegWidth  = 1'b1
  } reg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            ld_en;      // store one loaded pixel
    logic            match_set;  // last pixel loaded, arm the match flag
    logic            rd_issue;   // fetch the eroded row for a readout beat
    logic            out_load;   // fill the output register
    logic            out_ok;     // result is valid (image processed)
    logic            prc_dil;    // current pass is the dilation pass
    logic            prc_init;   // first tap of a row: clear the accumulator
    logic            prc_rd;     // fetch a neighbor row
    logic            prc_acc;    // fold the fetched row into the accumulator
    logic            prc_wr;     // last tap: write or check the row
    logic [RowW-1:0] prc_row;    // row under work
    logic [RowW-1:0] prc_nrow;   // neighbor row being fetched
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            ld_last;    // next load is the final pixel
    logic            out_free;   // output register can take a beat
    logic [RowW-1:0] height_m1;  // index of the last row
  } status_t;

  // A zero dimension becomes one, a value above the maximum saturates.
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/bocc_ctrl.sv */
module bocc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              action_i,
  input  logic              cfg_we_i,
  input  bocc_pkg::status_t st_i,
  output logic              s_ready_o,
  output bocc_pkg::cmd_t    cmd_o
);
  import bocc_pkg::*;

  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SEro  = 4'b0010,
    SDil  = 4'b0100,
    SRead = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [1:0]      tap_q, tap_d;
  logic [RowW-1:0] prow_q, prow_d;
  logic            done_q, done_d;
  logic            accept;
  logic            in_proc;

  assign s_ready_o = (state_q == SIdle);
  assign accept    = s_valid_i & s_ready_o;
  assign in_proc   = (state_q == SEro) || (state_q == SDil);

  always_comb begin
    cmd_o           = '0;
    cmd_o.ld_en     = accept && (action_i == ActLoad) && !done_q;
    cmd_o.match_set = cmd_o.ld_en && st_i.ld_last;
    cmd_o.rd_issue  = accept && (action_i == ActRead) && done_q;
    cmd_o.out_load  = (state_q == SRead) && st_i.out_free;
    cmd_o.out_ok    = done_q;
    cmd_o.prc_dil   = (state_q == SDil);
    cmd_o.prc_row   = prow_q;
    // Taps 0..2 fetch rows r-1, r, r+1; rows outside the image are skipped.
    cmd_o.prc_nrow  = prow_q + RowW'(tap_q) - RowW'(1);
    if (in_proc) begin
      cmd_o.prc_init = (tap_q == 2'd0);
      cmd_o.prc_rd   = ((tap_q == 2'd0) && (prow_q != '0)) || (tap_q == 2'd1) ||
                       ((tap_q == 2'd2) && (prow_q != st_i.height_m1));
      cmd_o.prc_acc  = (tap_q == 2'd1) || (tap_q == 2'd2);
      cmd_o.prc_wr   = (tap_q == 2'd3);
    end
  end

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    prow_d  = prow_q;
    done_d  = done_q;
    case (state_q)
      SIdle: begin
        if (cmd_o.match_set) begin
          state_d = SEro;
          tap_d   = '0;
          prow_d  = '0;
        end else if (accept && (action_i == ActRead)) begin
          state_d = SRead;
        end
      end
      SEro, SDil: begin
        tap_d = tap_q + 2'd1;
        if (tap_q == 2'd3) begin
          if (prow_q == st_i.height_m1) begin
            prow_d = '0;
            if (state_q == SEro) begin
              state_d = SDil;
            end else begin
              state_d = SIdle;
              done_d  = 1'b1;
            end
          end else begin
            prow_d = prow_q + RowW'(1);
          end
        end
      end
      SRead: begin
        if (st_i.out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    if (cfg_we_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      tap_q   <= '0;
      prow_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      prow_q  <= prow_d;
      done_q  <= done_d;
    end
  end

endmodule

/* hw/rtl/bocc_dpath.sv */
module bocc_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bocc_pkg::cmd_t            cmd_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bocc_pkg::DimW-1:0] cfg_data_i,
  input  logic                      pixel_i,
  input  logic                      m_ready_i,
  output logic                      m_valid_o,
  output logic                      m_pixel_o,
  output logic                      m_match_o,
  output logic                      m_ok_o,
  output logic                      m_last_o,
  output bocc_pkg::status_t         st_o
);
  import bocc_pkg::*;

  // Row-wide stores: one word holds one image row.
  logic [MaxCols-1:0] orig_mem [MaxRows];
  logic [MaxCols-1:0] ero_mem  [MaxRows];

  logic [DimW-1:0]    h_q, w_q, h_m1_full, w_m1_full;
  logic [RowW-1:0]    h_m1;
  logic [ColW-1:0]    w_m1;
  logic [RowW-1:0]    ld_row_q, rd_row_q;
  logic [ColW-1:0]    ld_col_q, rd_col_q;
  logic [MaxCols-1:0] rowbuf_q, rowbuf_d;
  logic [MaxCols-1:0] orig_rdata_q, ero_rdata_q;
  logic [MaxCols-1:0] acc_q, din, vsum, ero_row, dil_row, col_mask, col_last;
  logic               prc_vld_q;
  logic               match_q;
  logic               mismatch;
  logic               ld_last, rd_last;
  logic               out_valid_q, out_pixel_q, out_match_q, out_ok_q, out_last_q;
  logic               orig_re, ero_re;
  logic [RowW-1:0]    orig_ra, ero_ra;

  assign h_m1_full = h_q - DimW'(1);
  assign w_m1_full = w_q - DimW'(1);
  assign h_m1      = h_m1_full[RowW-1:0];
  assign w_m1      = w_m1_full[ColW-1:0];

  assign ld_last = (ld_row_q == h_m1) && (ld_col_q == w_m1);
  assign rd_last = (rd_row_q == h_m1) && (rd_col_q == w_m1);

  assign st_o.ld_last   = ld_last;
  assign st_o.out_free  = !out_valid_q || m_ready_i;
  assign st_o.height_m1 = h_m1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= HeightReset;
      w_q <= WidthReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegHeight) begin
        h_q <= clamp_dim(cfg_data_i, HeightReset);
      end else begin
        w_q <= clamp_dim(cfg_data_i, WidthReset);
      end
    end
  end

  // Load side: gather a row, write it to the store when it is complete.
  always_comb begin
    rowbuf_d = rowbuf_q;
    rowbuf_d[ld_col_q] = pixel_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_en) begin
      rowbuf_q <= rowbuf_d;
      if (ld_col_q == w_m1) begin
        orig_mem[ld_row_q] <= rowbuf_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_row_q <= '0;
      ld_col_q <= '0;
      rd_row_q <= '0;
      rd_col_q <= '0;
    end else if (cfg_we_i) begin
      ld_row_q <= '0;
      ld_col_q <= '0;
      rd_row_q <= '0;
      rd_col_q <= '0;
    end else begin
      if (cmd_i.ld_en) begin
        if (ld_col_q == w_m1) begin
          ld_col_q <= '0;
          ld_row_q <= ld_row_q + RowW'(1);
        end else begin
          ld_col_q <= ld_col_q + ColW'(1);
        end
      end
      if (cmd_i.out_load && cmd_i.out_ok) begin
        if (rd_last) begin
          rd_row_q <= '0;
          rd_col_q <= '0;
        end else if (rd_col_q == w_m1) begin
          rd_col_q <= '0;
          rd_row_q <= rd_row_q + RowW'(1);
        end else begin
          rd_col_q <= rd_col_q + ColW'(1);
        end
      end
    end
  end

  // Store read ports. The dilation pass reads the original row once, at its
  // first tap, for the comparison at the last tap.
  assign orig_re = cmd_i.prc_dil ? cmd_i.prc_init : cmd_i.prc_rd;
  assign orig_ra = cmd_i.prc_dil ? cmd_i.prc_row : cmd_i.prc_nrow;
  assign ero_re  = cmd_i.rd_issue || (cmd_i.prc_dil && cmd_i.prc_rd);
  assign ero_ra  = cmd_i.rd_issue ? rd_row_q : cmd_i.prc_nrow;

  always_ff @(posedge clk_i) begin
    if (orig_re) begin
      orig_rdata_q <= orig_mem[orig_ra];
    end
    if (ero_re) begin
      ero_rdata_q <= ero_mem[ero_ra];
    end
    if (cmd_i.prc_wr && !cmd_i.prc_dil) begin
      ero_mem[cmd_i.prc_row] <= ero_row;
    end
  end

  // Vertical fold: AND of rows for erosion, OR for dilation. Rows outside
  // the image give the identity of the operation.
  always_comb begin
    if (prc_vld_q) begin
      din = cmd_i.prc_dil ? ero_rdata_q : orig_rdata_q;
    end else begin
      din = cmd_i.prc_dil ? '0 : '1;
    end
    vsum = cmd_i.prc_dil ? (acc_q | din) : (acc_q & din);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prc_vld_q <= 1'b0;
    end else begin
      prc_vld_q <= cmd_i.prc_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prc_init) begin
      acc_q <= cmd_i.prc_dil ? '0 : '1;
    end else if (cmd_i.prc_acc) begin
      acc_q <= vsum;
    end
  end

  // Horizontal step over the columns of the row.
  always_comb begin
    logic left_e, right_e, left_d, right_d;
    for (int c = 0; c < MaxCols; c++) begin
      col_mask[c] = DimW'(c) < w_q;
      col_last[c] = DimW'(c) == w_m1_full;
    end
    for (int c = 0; c < MaxCols; c++) begin
      left_e  = 1'b1;
      right_e = 1'b1;
      left_d  = 1'b0;
      right_d = 1'b0;
      if (c > 0) begin
        left_e = vsum[c-1];
        left_d = vsum[c-1];
      end
      if (c < MaxCols - 1) begin
        right_d = vsum[c+1];
        if (!col_last[c]) begin
          right_e = vsum[c+1];
        end
      end
      ero_row[c] = vsum[c] & left_e & right_e & col_mask[c];
      dil_row[c] = vsum[c] | left_d | right_d;
    end
  end

  assign mismatch = |((dil_row ^ orig_rdata_q) & col_mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmd_i.match_set) begin
      match_q <= 1'b1;
    end else if (cmd_i.prc_wr && cmd_i.prc_dil && mismatch) begin
      match_q <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pixel_q <= cmd_i.out_ok & ero_rdata_q[rd_col_q];
      out_match_q <= cmd_i.out_ok & match_q;
      out_ok_q    <= cmd_i.out_ok;
      out_last_q  <= cmd_i.out_ok & rd_last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_pixel_o = out_pixel_q;
  assign m_match_o = out_match_q;
  assign m_ok_o    = out_ok_q;
  assign m_last_o  = out_last_q;

endmodule

/* hw/rtl/binary_opening_check_3x3_core.sv */
// Binary 3x3 opening with a match check. Load beats (tuser 0) carry one pixel
// each in raster order and are taken at one per cycle; they give no output.
// Once height times width pixels are in, the core erodes the image with a 3x3
// square (neighbors outside the image do not erode), dilates the result with
// the same square and compares it against the original. Both passes work a
// whole row at a time over row-wide stores, each row in taps that fetch rows
// r-1, r and r+1 and a last tap that writes or checks it; tready stays low
// from the final pixel until both passes are done. Read beats (tuser 1) then
// return the eroded pixels in raster order, one output beat per read, with
// the match flag, tuser 1 and tlast on the final pixel; the readout wraps and
// repeats. A read goes through a store read, then the output register, and
// the next beat is taken while the previous result still waits in the output
// register. A read before processing has finished returns one beat with every
// field zero. Loads after processing are dropped. Writing a dimension register
// (0 height, 1 width, 1..64, a zero becomes one and larger values saturate)
// restarts the core; write only while it is idle.
module binary_opening_check_3x3_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [0] pixel_in, rest zero
  input  logic                      s_axis_tuser,   // [0] action

  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [0] eroded_pixel, [1] opening_matches
  output logic                      m_axis_tuser,   // [0] ready_res
  output logic                      m_axis_tlast,   // last_pixel

  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bocc_pkg::DimW-1:0] cfg_data_i
);
  import bocc_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    out_pixel, out_match;

  // Sequencer: accepts beats, steps through the two row passes and the
  // readout handshake.
  bocc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .action_i  (s_axis_tuser),
    .cfg_we_i  (cfg_we_i),
    .st_i      (st),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  // Stores, counters, the row-wide window logic and the output register.
  bocc_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pixel_i    (s_axis_tdata[0]),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_pixel_o  (out_pixel),
    .m_match_o  (out_match),
    .m_ok_o     (m_axis_tuser),
    .m_last_o   (m_axis_tlast),
    .st_o       (st)
  );

  assign m_axis_tdata = {6'b0, out_match, out_pixel};

endmodule
